### rtl/iccc_pkg.sv
package iccc_pkg;

  localparam int unsigned SrcSlots = 32;
  localparam int unsigned IdW      = 5;
  localparam int unsigned PrioW    = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned AddrW    = 4;

  localparam logic [CmdW-1:0] CmdRaise   = 3'd0;
  localparam logic [CmdW-1:0] CmdLower   = 3'd1;
  localparam logic [CmdW-1:0] CmdWrPrio  = 3'd2;
  localparam logic [CmdW-1:0] CmdRdPrio  = 3'd3;
  localparam logic [CmdW-1:0] CmdClaim   = 3'd4;
  localparam logic [CmdW-1:0] CmdDone    = 3'd5;
  localparam logic [CmdW-1:0] CmdRdPend  = 3'd6;

  localparam logic [1:0] RegMThr = 2'd0;
  localparam logic [1:0] RegSThr = 2'd1;
  localparam logic [1:0] RegMEn  = 2'd2;
  localparam logic [1:0] RegSEn  = 2'd3;

  typedef struct packed {
    logic [PrioW-1:0] m_thr;
    logic [PrioW-1:0] s_thr;
    logic             m_en;
    logic             s_en;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take the input transaction
    logic scan;    // issue next priority read of the claim scan
    logic exec;    // execute a non-claim command and load the result
    logic commit;  // finish a claim and load the result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_claim;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/iccc_ctrl.sv
module iccc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iccc_pkg::sts_t sts_i,
  output iccc_pkg::ctl_t ctl_o
);
  import iccc_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScan   = 5'b00010,
    StDrain  = 5'b00100,
    StCommit = 5'b01000,
    StExec   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = sts_i.is_claim ? StScan : StExec;
        end
      end
      StScan: begin
        ctl_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // last priority read is compared here
        state_d = StCommit;
      end
      StCommit: begin
        if (sts_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      StExec: begin
        if (sts_i.out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/iccc_dp.sv
module iccc_dp #(
  parameter int unsigned NUM_SOURCES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iccc_pkg::ctl_t                ctl_i,
  output iccc_pkg::sts_t                sts_o,
  input  iccc_pkg::cfg_t                cfg_i,
  input  logic [iccc_pkg::CmdW-1:0]     cmd_i,
  input  logic [iccc_pkg::IdW-1:0]      source_i,
  input  logic [iccc_pkg::DataW-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [iccc_pkg::DataW-1:0]    read_data_o,
  output logic                          machine_irq_o,
  output logic                          supervisor_irq_o
);
  import iccc_pkg::*;

  localparam logic [31:0] NumSrc = 32'(NUM_SOURCES);

  function automatic logic src_ok(input logic [IdW-1:0] id);
    return (id != '0) && ({{(32-IdW){1'b0}}, id} < NumSrc);
  endfunction

  // latched transaction
  logic [CmdW-1:0]  cmd_q;
  logic [IdW-1:0]   src_q;
  logic [DataW-1:0] val_q;

  // priority memory, entries read as zero until written
  logic [PrioW-1:0]    prio_mem [SrcSlots];
  logic [SrcSlots-1:0] prio_vld_q;
  logic [IdW-1:0]      raddr;
  logic [PrioW-1:0]    rdata_q;
  logic                rvld_q;
  logic [PrioW-1:0]    prio_eff;
  logic                mem_we;

  // interrupt state
  logic [SrcSlots-1:0] pend_q, pend_d;
  logic [SrcSlots-1:0] clm_q, clm_d;
  logic                m_line_q, m_line_d;
  logic                s_line_q, s_line_d;
  logic [DataW-1:0]    data_d;

  // claim scan
  logic [IdW-1:0]   scan_idx_q;
  logic [IdW-1:0]   cmp_idx_q;
  logic             cmp_en_q;
  logic             found_q;
  logic [IdW-1:0]   best_id_q;
  logic [PrioW-1:0] best_prio_q;
  logic [SrcSlots-1:0] waiting;
  logic             take;

  // result register
  logic             out_valid_q;
  logic [DataW-1:0] out_data_q;
  logic             out_m_q;
  logic             out_s_q;
  logic             done_ok;

  assign sts_o.is_claim  = (cmd_i == CmdClaim);
  assign sts_o.scan_last = (scan_idx_q == IdW'(SrcSlots - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign raddr = ctl_i.load ? source_i : (ctl_i.scan ? scan_idx_q : src_q);
  assign mem_we = ctl_i.exec && (cmd_q == CmdWrPrio) && src_ok(src_q);
  assign prio_eff = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prio_mem[src_q] <= val_q[PrioW-1:0];
    end
    rdata_q <= prio_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_vld_q <= '0;
      rvld_q     <= 1'b0;
    end else begin
      if (mem_we) begin
        prio_vld_q[src_q] <= 1'b1;
      end
      rvld_q <= prio_vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      src_q <= source_i;
      val_q <= value_i;
    end
  end

  assign waiting = pend_q & ~clm_q;
  assign take    = cmp_en_q && waiting[cmp_idx_q] && src_ok(cmp_idx_q) &&
                   (!found_q || (prio_eff > best_prio_q));

  // read issued at scan_idx lands in the next cycle, tagged by cmp_idx
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      cmp_idx_q   <= '0;
      cmp_en_q    <= 1'b0;
      found_q     <= 1'b0;
      best_id_q   <= '0;
      best_prio_q <= '0;
    end else if (ctl_i.load) begin
      scan_idx_q  <= IdW'(1);
      cmp_en_q    <= 1'b0;
      found_q     <= 1'b0;
      best_id_q   <= '0;
      best_prio_q <= '0;
    end else begin
      if (ctl_i.scan) begin
        scan_idx_q <= scan_idx_q + IdW'(1);
      end
      cmp_en_q  <= ctl_i.scan;
      cmp_idx_q <= scan_idx_q;
      if (take) begin
        found_q     <= 1'b1;
        best_id_q   <= cmp_idx_q;
        best_prio_q <= prio_eff;
      end
    end
  end

  assign done_ok = (val_q[DataW-1:IdW] == '0) && src_ok(val_q[IdW-1:0]);

  always_comb begin
    pend_d   = pend_q;
    clm_d    = clm_q;
    m_line_d = m_line_q;
    s_line_d = s_line_q;
    data_d   = '0;
    if (ctl_i.exec) begin
      case (cmd_q)
        CmdRaise: begin
          if (src_ok(src_q)) begin
            pend_d = pend_q | (SrcSlots'(1) << src_q);
            if (prio_eff != '0) begin
              if ((prio_eff >= cfg_i.m_thr) && cfg_i.m_en) begin
                m_line_d = 1'b1;
              end
              if ((prio_eff >= cfg_i.s_thr) && cfg_i.s_en) begin
                s_line_d = 1'b1;
              end
            end
          end
        end
        CmdLower: begin
          m_line_d = 1'b0;
          s_line_d = 1'b0;
        end
        CmdRdPrio: begin
          if (src_ok(src_q)) begin
            data_d = {{(DataW-PrioW){1'b0}}, prio_eff};
          end
        end
        CmdDone: begin
          if (done_ok) begin
            pend_d = pend_q & ~(SrcSlots'(1) << val_q[IdW-1:0]);
            clm_d  = clm_q & ~(SrcSlots'(1) << val_q[IdW-1:0]);
          end
        end
        CmdRdPend: begin
          data_d = pend_q;
        end
        default: begin
          data_d = '0;
        end
      endcase
    end
    if (ctl_i.commit) begin
      data_d = {{(DataW-IdW){1'b0}}, best_id_q};
      if (found_q) begin
        clm_d = clm_q | (SrcSlots'(1) << best_id_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      clm_q    <= '0;
      m_line_q <= 1'b0;
      s_line_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      clm_q    <= clm_d;
      m_line_q <= m_line_d;
      s_line_q <= s_line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.exec || ctl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec || ctl_i.commit) begin
      out_data_q <= data_d;
      out_m_q    <= m_line_d;
      out_s_q    <= s_line_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_data_q;
  assign machine_irq_o    = out_m_q;
  assign supervisor_irq_o = out_s_q;

endmodule

### rtl/interrupt_claim_complete_controller_core.sv
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    cmd_i, source_i, value_i
// out       out_valid_o / out_ready_i  read_data_o, machine_irq_o, supervisor_irq_o
// apb       psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A claim scans the sources, reading one priority per cycle from the single
// read port of the priority memory. One transaction is in work at a time.
// Reset clears the control and interrupt state at once; the priority memory
// is not cleared, its entries read as zero until written, so no clearing pass.
// A held result stalls only the finish of the next transaction.
module interrupt_claim_complete_controller_core #(
  parameter int unsigned NUM_SOURCES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [iccc_pkg::CmdW-1:0]     cmd_i,
  input  logic [iccc_pkg::IdW-1:0]      source_i,
  input  logic [iccc_pkg::DataW-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [iccc_pkg::DataW-1:0]    read_data_o,
  output logic                          machine_irq_o,
  output logic                          supervisor_irq_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iccc_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import iccc_pkg::*;

  cfg_t cfg_q;
  ctl_t ctl;
  sts_t sts;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        RegMThr: cfg_q.m_thr <= pwdata[PrioW-1:0];
        RegSThr: cfg_q.s_thr <= pwdata[PrioW-1:0];
        RegMEn:  cfg_q.m_en  <= pwdata[0];
        RegSEn:  cfg_q.s_en  <= pwdata[0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegMThr: prdata = {{(32-PrioW){1'b0}}, cfg_q.m_thr};
      RegSThr: prdata = {{(32-PrioW){1'b0}}, cfg_q.s_thr};
      RegMEn:  prdata = {31'b0, cfg_q.m_en};
      RegSEn:  prdata = {31'b0, cfg_q.s_en};
      default: prdata = '0;
    endcase
  end

  iccc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  iccc_dp #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd_i),
    .source_i         (source_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .machine_irq_o    (machine_irq_o),
    .supervisor_irq_o (supervisor_irq_o)
  );

`ifndef NO_ASSERTIONS
  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a transaction is in work");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.exec || ctl.commit) |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  a_single_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.exec && ctl.commit) && !(ctl.load && (ctl.scan || ctl.exec || ctl.commit)))
    else $error("conflicting datapath commands");
`endif

endmodule
